// File: rtl/core/tmgc_pkg.sv
// ----------------------------------------------------------------------------
// tmgc_pkg
// Shared types and constants of the template match gesture classifier:
// sample and distance widths, the token that runs down the cell chain,
// the configuration write bundle and the register indexes.
// ----------------------------------------------------------------------------
package tmgc_pkg;

    // Widths of the sample and profile fields.
    localparam int SAMPLE_W     = 10;
    localparam int FINGER_PORTS = 4;
    localparam int PROFILE_W    = 41;
    localparam int RECORDED_BIT = 40;
    localparam int DIST_W       = 16;
    localparam int CLASS_W      = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 41;
    localparam int HOLD_W       = 16;
    localparam int COUNT_W      = 8;

    // Register indexes of the configuration port.
    localparam int                   PROFILE_REGS    = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATED  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_COUNTS = 3'd7;

    // Reset value of the hold counts: compose 3, debounce 2.
    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd515;

    // Class codes and distance markers.
    localparam logic [CLASS_W-1:0] NONE_CLASS = 3'd6;
    localparam logic [DIST_W-1:0]  UNRECORDED = 16'hFFFF;

    // Threshold arithmetic. The separation is capped where the clamp to the
    // upper bound already decides the result, so the scaled value stays small.
    localparam int                SEP_CAP_W   = 11;
    localparam logic [SEP_CAP_W-1:0] SEP_CAP  = 11'd2047;
    localparam logic [DIST_W-1:0] NO_SEP      = 16'd100;
    localparam int                SCALED_W    = 13;
    localparam int                RECIP_W     = 16;
    localparam logic [RECIP_W-1:0] RECIP_10   = 16'd52429;
    localparam int                RECIP_SHIFT = 19;
    localparam int                PROD_W      = SCALED_W + RECIP_W;
    localparam int                QUOT_W      = 10;
    localparam logic [DIST_W-1:0] THR_MIN     = 16'd50;
    localparam logic [DIST_W-1:0] THR_MAX     = 16'd400;
    localparam logic [COUNT_W-1:0] STABLE_MAX = 8'd255;

    typedef logic [SAMPLE_W-1:0]  t_sample;
    typedef logic [DIST_W-1:0]    t_dist;
    typedef logic [CLASS_W-1:0]   t_class;
    typedef logic [FINGER_PORTS-1:0][SAMPLE_W-1:0] t_samples;

    // Data carried from cell to cell along the chain.
    typedef struct packed {
        t_samples samples;
        t_dist    min_d;
        t_dist    sec_d;
        t_class   best;
    } t_token;

    // One configuration write.
    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

// File: rtl/core/tmgc_cell.sv
// ----------------------------------------------------------------------------
// tmgc_cell
// One cell of the profile chain. It holds one gesture profile, forms the L1
// distance of the passing sample set to it, and folds that distance into the
// running nearest and second-nearest result before handing it on.
// ----------------------------------------------------------------------------
module tmgc_cell #(
    parameter int G_IDX   = 0,
    parameter int FINGERS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  tmgc_pkg::t_cfg_wr i_cfg,
    input  logic             i_valid,
    input  tmgc_pkg::t_token i_token,
    output logic             o_valid,
    output tmgc_pkg::t_token o_token
);
    import tmgc_pkg::*;

    localparam int NF       = (FINGERS < FINGER_PORTS) ? FINGERS : FINGER_PORTS;
    localparam bit WRITABLE = (G_IDX < PROFILE_REGS);

    logic [PROFILE_W-1:0] r_profile;
    t_dist                n_dist;
    t_token               n_token;
    logic                 r_valid;
    t_token               r_token;

    // Profile register; only the cells backed by a register can be written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_profile <= '0;
        end else if (WRITABLE && i_cfg.we && (i_cfg.index == CFG_IDX_W'(G_IDX))) begin
            r_profile <= i_cfg.data[PROFILE_W-1:0];
        end
    end

    // L1 distance over the compared fingers.
    always_comb begin : dist_calc
        t_sample tv;
        t_sample sv;
        tv     = '0;
        sv     = '0;
        n_dist = '0;
        for (int f = 0; f < NF; f++) begin
            tv = r_profile[f*SAMPLE_W +: SAMPLE_W];
            sv = i_token.samples[f];
            n_dist = n_dist + ((sv > tv) ? DIST_W'(sv - tv) : DIST_W'(tv - sv));
        end
        if (!r_profile[RECORDED_BIT]) begin
            n_dist = UNRECORDED;
        end
    end

    // Running top two; a tie keeps the earlier (lower index) profile.
    always_comb begin
        n_token = i_token;
        if (n_dist < i_token.min_d) begin
            n_token.sec_d = i_token.min_d;
            n_token.min_d = n_dist;
            n_token.best  = CLASS_W'(G_IDX);
        end else if (n_dist < i_token.sec_d) begin
            n_token.sec_d = n_dist;
        end
    end

    // Hand the token to the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_token <= n_token;
        end
    end

    assign o_valid = r_valid;
    assign o_token = r_token;

endmodule

// File: rtl/core/tmgc_thresh.sv
// ----------------------------------------------------------------------------
// tmgc_thresh
// Adaptive threshold and class decision. Stage one scales the separation
// between the two nearest profiles by 3/10 through a reciprocal multiply;
// stage two adds the minimum, clamps to 50..400 or uses the fallback, and picks the class.
// ----------------------------------------------------------------------------
module tmgc_thresh #(
    parameter int FALLBACK_THRESHOLD = 200
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_valid,
    input  tmgc_pkg::t_token i_token,
    output logic             o_valid,
    output tmgc_pkg::t_class o_class
);
    import tmgc_pkg::*;

    t_dist                 sep;
    logic [SEP_CAP_W-1:0]  sep_cap;
    logic [SCALED_W-1:0]   scaled;
    logic [PROD_W-1:0]     n_prod;

    logic                  r_s1_valid;
    logic [PROD_W-1:0]     r_s1_prod;
    t_dist                 r_s1_min;
    t_class                r_s1_best;

    logic [QUOT_W-1:0]     quot;
    logic [DIST_W:0]       thr_sum;
    t_dist                 thr;
    t_class                n_class;

    logic                  r_s2_valid;
    t_class                r_s2_class;

    // Separation, capped, times three, times the reciprocal of ten.
    always_comb begin
        sep     = (i_token.sec_d > i_token.min_d) ? (i_token.sec_d - i_token.min_d) : NO_SEP;
        sep_cap = (sep > DIST_W'(SEP_CAP)) ? SEP_CAP : sep[SEP_CAP_W-1:0];
        scaled  = SCALED_W'(sep_cap) * SCALED_W'(3);
        n_prod  = PROD_W'(scaled) * PROD_W'(RECIP_10);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_prod <= n_prod;
            r_s1_min  <= i_token.min_d;
            r_s1_best <= i_token.best;
        end
    end

    // Threshold with clamp, fallback when nothing is recorded, class pick.
    always_comb begin
        quot    = r_s1_prod[RECIP_SHIFT +: QUOT_W];
        thr_sum = (DIST_W+1)'(r_s1_min) + (DIST_W+1)'(quot);
        if (thr_sum < (DIST_W+1)'(THR_MIN)) begin
            thr = THR_MIN;
        end else if (thr_sum > (DIST_W+1)'(THR_MAX)) begin
            thr = THR_MAX;
        end else begin
            thr = thr_sum[DIST_W-1:0];
        end
        if (r_s1_best == NONE_CLASS) begin
            thr = DIST_W'(FALLBACK_THRESHOLD);
        end
        n_class = (r_s1_min > thr) ? NONE_CLASS : r_s1_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s2_class <= n_class;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_class = r_s2_class;

endmodule

// File: rtl/core/tmgc_debounce.sv
// ----------------------------------------------------------------------------
// tmgc_debounce
// Debounce of the raw class and the output register. Holds the calibrated
// flag and the hold counts, plus the last class, compose and stable counts.
// ----------------------------------------------------------------------------
module tmgc_debounce (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  tmgc_pkg::t_cfg_wr i_cfg,
    input  logic              i_valid,
    input  tmgc_pkg::t_class  i_class,
    output logic              o_valid,
    output tmgc_pkg::t_class  o_gesture
);
    import tmgc_pkg::*;

    logic                r_calibrated;
    logic [HOLD_W-1:0]   r_hold;
    t_class              r_last;
    t_class              n_last;
    logic [COUNT_W-1:0]  r_compose;
    logic [COUNT_W-1:0]  n_compose;
    logic [COUNT_W-1:0]  r_stable;
    logic [COUNT_W-1:0]  n_stable;
    t_class              n_out;
    logic                r_out_valid;
    t_class              r_out;
    logic [COUNT_W-1:0]  compose_ticks;
    logic [COUNT_W-1:0]  debounce_cnt;

    // Configuration registers owned by this stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calibrated <= 1'b0;
            r_hold       <= HOLD_RESET;
        end else if (i_cfg.we) begin
            if (i_cfg.index == CFG_CALIBRATED) begin
                r_calibrated <= i_cfg.data[0];
            end
            if (i_cfg.index == CFG_HOLD_COUNTS) begin
                r_hold <= i_cfg.data[HOLD_W-1:0];
            end
        end
    end

    assign compose_ticks = r_hold[COUNT_W-1:0];
    assign debounce_cnt  = r_hold[HOLD_W-1:COUNT_W];

    // Next debounce state and output value for one transaction.
    always_comb begin
        n_last    = r_last;
        n_compose = r_compose;
        n_stable  = r_stable;
        n_out     = NONE_CLASS;
        if (r_calibrated) begin
            if (i_class != r_last) begin
                n_last    = i_class;
                n_compose = COUNT_W'(1);
                n_stable  = '0;
            end else if (r_compose < compose_ticks) begin
                n_compose = r_compose + COUNT_W'(1);
            end else begin
                if (r_stable < STABLE_MAX) begin
                    n_stable = r_stable + COUNT_W'(1);
                end
                if (n_stable >= debounce_cnt) begin
                    n_out = i_class;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= NONE_CLASS;
            r_compose <= '0;
            r_stable  <= '0;
        end else if (i_adv && i_valid) begin
            r_last    <= n_last;
            r_compose <= n_compose;
            r_stable  <= n_stable;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_gesture = r_out;

endmodule

// File: rtl/core/template_match_gesture_classifier_core.sv
// ----------------------------------------------------------------------------
// template_match_gesture_classifier_core
// Nearest-template L1 gesture classifier with adaptive threshold and debounce.
// ----------------------------------------------------------------------------
// The block accepts one set of finger samples per clock unless stalled and
// delivers one detected gesture per set, in order, after one register in
// each profile cell of the chain, two in the threshold stages and the
// debounce output register. A stalled output register freezes the whole
// pipeline, so o_stall follows i_stall whenever a result is waiting. The
// user must write profiles, the calibrated flag and the hold counts through
// the configuration port while no transaction is in flight; not enforced.
// ----------------------------------------------------------------------------
module template_match_gesture_classifier_core #(
    parameter int FINGERS            = 4,
    parameter int GESTURES           = 6,
    parameter int FALLBACK_THRESHOLD = 200
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tmgc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tmgc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [tmgc_pkg::SAMPLE_W-1:0]    i_finger_sample_0,
    input  logic [tmgc_pkg::SAMPLE_W-1:0]    i_finger_sample_1,
    input  logic [tmgc_pkg::SAMPLE_W-1:0]    i_finger_sample_2,
    input  logic [tmgc_pkg::SAMPLE_W-1:0]    i_finger_sample_3,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [tmgc_pkg::CLASS_W-1:0]     o_detected_gesture
);
    import tmgc_pkg::*;

    t_cfg_wr cfg;
    logic    adv;
    logic    chain_valid [GESTURES+1];
    t_token  chain_token [GESTURES+1];
    logic    thr_valid;
    t_class  thr_class;

    // Configuration write bundle.
    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    // The pipeline moves unless a finished result is held by a stall.
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    // Entry token: no profile seen yet.
    assign chain_valid[0]               = i_valid;
    assign chain_token[0].samples[0]    = i_finger_sample_0;
    assign chain_token[0].samples[1]    = i_finger_sample_1;
    assign chain_token[0].samples[2]    = i_finger_sample_2;
    assign chain_token[0].samples[3]    = i_finger_sample_3;
    assign chain_token[0].min_d         = UNRECORDED;
    assign chain_token[0].sec_d         = UNRECORDED;
    assign chain_token[0].best          = NONE_CLASS;

    // Chain of profile cells.
    for (genvar g = 0; g < GESTURES; g++) begin : g_cell
        tmgc_cell #(
            .G_IDX   (g),
            .FINGERS (FINGERS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_cfg   (cfg),
            .i_valid (chain_valid[g]),
            .i_token (chain_token[g]),
            .o_valid (chain_valid[g+1]),
            .o_token (chain_token[g+1])
        );
    end

    // Threshold and class decision.
    tmgc_thresh #(
        .FALLBACK_THRESHOLD (FALLBACK_THRESHOLD)
    ) u_thresh (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (chain_valid[GESTURES]),
        .i_token (chain_token[GESTURES]),
        .o_valid (thr_valid),
        .o_class (thr_class)
    );

    // Debounce and output register.
    tmgc_debounce u_debounce (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_cfg     (cfg),
        .i_valid   (thr_valid),
        .i_class   (thr_class),
        .o_valid   (o_valid),
        .o_gesture (o_detected_gesture)
    );

endmodule
